FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/bvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_pkg
// opcodes, widths and shared types of the byte machine execute block
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int PROGRAM_DEPTH_DEF = 256;

    localparam int NUM_REGS = 16;
    localparam int REG_AW   = 4;
    localparam int DATA_W   = 8;

    localparam logic [7:0] OP_INC  = 8'h01;
    localparam logic [7:0] OP_DEC  = 8'h02;
    localparam logic [7:0] OP_MOV  = 8'h03;
    localparam logic [7:0] OP_MOVC = 8'h04;
    localparam logic [7:0] OP_LSL  = 8'h05;
    localparam logic [7:0] OP_LSR  = 8'h06;
    localparam logic [7:0] OP_JMP  = 8'h07;
    localparam logic [7:0] OP_JZ   = 8'h08;
    localparam logic [7:0] OP_JNZ  = 8'h09;
    localparam logic [7:0] OP_JFE  = 8'h0A;
    localparam logic [7:0] OP_RET  = 8'h0B;
    localparam logic [7:0] OP_ADD  = 8'h0C;
    localparam logic [7:0] OP_SUB  = 8'h0D;
    localparam logic [7:0] OP_XOR  = 8'h0E;
    localparam logic [7:0] OP_OR   = 8'h0F;
    localparam logic [7:0] OP_IN   = 8'h10;
    localparam logic [7:0] OP_OUT  = 8'h11;

    // bit positions of the result flags in m_axis_tuser
    localparam int UB_OUT_VALID = 0;
    localparam int UB_TAKEN     = 1;
    localparam int UB_ZERO      = 2;
    localparam int UB_END       = 3;
    localparam int UB_HALTED    = 4;
    localparam int OUT_USER_W   = 5;

    typedef struct packed {
        logic                we;
        logic [REG_AW-1:0]   waddr;
        logic [DATA_W-1:0]   wdata;
        logic                zero;
        logic                end_seen;
        logic                halted;
        logic                out_valid;
        logic [DATA_W-1:0]   out_char;
        logic                taken;
    } ex_res_t;

endpackage

FILE: hdl/bvm_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_regfile
// sixteen-entry register memory, one write and two registered reads,
// with reset-valid bits and write-to-read forwarding
// ----------------------------------------------------------------------------
module bvm_regfile
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [bvm_pkg::REG_AW-1:0]          rx_addr,
    input  logic [bvm_pkg::REG_AW-1:0]          ry_addr,
    output logic [bvm_pkg::DATA_W-1:0]          rx_val,
    output logic [bvm_pkg::DATA_W-1:0]          ry_val,
    input  logic                                we,
    input  logic [bvm_pkg::REG_AW-1:0]          waddr,
    input  logic [bvm_pkg::DATA_W-1:0]          wdata
);

    logic [bvm_pkg::DATA_W-1:0]   mem [bvm_pkg::NUM_REGS];
    logic [bvm_pkg::NUM_REGS-1:0] vld_reg;
    logic [bvm_pkg::NUM_REGS-1:0] vld_next;

    logic [bvm_pkg::DATA_W-1:0]   rx_raw_reg;
    logic [bvm_pkg::DATA_W-1:0]   ry_raw_reg;
    logic [bvm_pkg::DATA_W-1:0]   fwd_data_reg;
    logic                         fwd_x_reg;
    logic                         fwd_y_reg;
    logic                         vld_x_reg;
    logic                         vld_y_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rx_raw_reg   <= mem[rx_addr];
            ry_raw_reg   <= mem[ry_addr];
            fwd_data_reg <= wdata;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (we)
        begin
            vld_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            fwd_x_reg <= 1'b0;
            fwd_y_reg <= 1'b0;
            vld_x_reg <= 1'b0;
            vld_y_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                // a write landing on the same edge wins over the array read
                fwd_x_reg <= we && (waddr == rx_addr);
                fwd_y_reg <= we && (waddr == ry_addr);
                vld_x_reg <= vld_reg[rx_addr];
                vld_y_reg <= vld_reg[ry_addr];
            end
        end
    end

    // entries never written read as zero
    assign rx_val = fwd_x_reg ? fwd_data_reg : (vld_x_reg ? rx_raw_reg : '0);
    assign ry_val = fwd_y_reg ? fwd_data_reg : (vld_y_reg ? ry_raw_reg : '0);

endmodule

FILE: hdl/bvm_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_alu
// decode and execute of one instruction: register result, flags and next pc
// ----------------------------------------------------------------------------
module bvm_alu
#(
    parameter int PROGRAM_DEPTH = bvm_pkg::PROGRAM_DEPTH_DEF
)
(
    input  logic [7:0]                          opcode,
    input  logic [7:0]                          operand,
    input  logic [7:0]                          input_char,
    input  logic                                input_end,
    input  logic [$clog2(PROGRAM_DEPTH)-1:0]    jump_off,
    input  logic [bvm_pkg::DATA_W-1:0]          rx_val,
    input  logic [bvm_pkg::DATA_W-1:0]          ry_val,
    input  logic                                zero_in,
    input  logic                                end_in,
    input  logic                                halted_in,
    input  logic [$clog2(PROGRAM_DEPTH)-1:0]    pc_in,
    output bvm_pkg::ex_res_t                    res,
    output logic [$clog2(PROGRAM_DEPTH)-1:0]    pc_out
);

    localparam int PC_W = $clog2(PROGRAM_DEPTH);

    logic                         set_zero;
    logic                         do_jump;
    logic                         do_step;
    logic [bvm_pkg::DATA_W-1:0]   new_rx;
    logic [PC_W-1:0]              pc_add;
    logic [PC_W:0]                pc_sum;

    always_comb
    begin
        res           = '0;
        res.waddr     = operand[bvm_pkg::REG_AW-1:0];
        res.wdata     = rx_val;
        res.end_seen  = end_in;
        res.halted    = halted_in;
        set_zero      = 1'b0;
        do_jump       = 1'b0;
        do_step       = 1'b1;

        case (opcode)
            bvm_pkg::OP_INC:
            begin
                res.we    = 1'b1;
                res.wdata = rx_val + 8'd1;
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_DEC:
            begin
                res.we    = 1'b1;
                res.wdata = rx_val - 8'd1;
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_MOV:
            begin
                res.we    = 1'b1;
                res.wdata = ry_val;
            end
            bvm_pkg::OP_MOVC:
            begin
                res.we    = 1'b1;
                res.waddr = '0;
                res.wdata = operand;
            end
            bvm_pkg::OP_LSL:
            begin
                res.we    = 1'b1;
                res.wdata = {rx_val[6:0], 1'b0};
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_LSR:
            begin
                res.we    = 1'b1;
                res.wdata = {1'b0, rx_val[7:1]};
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_JMP: do_jump = 1'b1;
            bvm_pkg::OP_JZ:  do_jump = zero_in;
            bvm_pkg::OP_JNZ: do_jump = !zero_in;
            bvm_pkg::OP_JFE: do_jump = end_in;
            bvm_pkg::OP_RET:
            begin
                res.halted = 1'b1;
                do_step    = 1'b0;
            end
            bvm_pkg::OP_ADD:
            begin
                res.we    = 1'b1;
                res.wdata = rx_val + ry_val;
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_SUB:
            begin
                res.we    = 1'b1;
                res.wdata = rx_val - ry_val;
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_XOR:
            begin
                res.we    = 1'b1;
                res.wdata = rx_val ^ ry_val;
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_OR:
            begin
                res.we    = 1'b1;
                res.wdata = rx_val | ry_val;
                set_zero  = 1'b1;
            end
            bvm_pkg::OP_IN:
            begin
                if (input_end)
                begin
                    res.end_seen = 1'b1;
                end
                else
                begin
                    res.we    = 1'b1;
                    res.wdata = input_char;
                    res.taken = 1'b1;
                end
                set_zero = 1'b1;
            end
            bvm_pkg::OP_OUT:
            begin
                res.out_valid = 1'b1;
                res.out_char  = rx_val;
            end
            default:
            begin
                do_step = 1'b1;
            end
        endcase

        // flag-setting ops always target rx
        new_rx   = res.we ? res.wdata : rx_val;
        res.zero = set_zero ? (new_rx == '0) : zero_in;

        // a halted machine ignores everything
        if (halted_in)
        begin
            res          = '0;
            res.zero     = zero_in;
            res.end_seen = end_in;
            res.halted   = 1'b1;
            do_jump      = 1'b0;
            do_step      = 1'b0;
        end
    end

    // both addends are below the depth, so one subtract wraps the sum
    always_comb
    begin
        if (do_jump)
        begin
            pc_add = jump_off;
        end
        else if (do_step)
        begin
            pc_add = PC_W'(1);
        end
        else
        begin
            pc_add = '0;
        end
        pc_sum = {1'b0, pc_in} + {1'b0, pc_add};
        if (pc_sum >= (PC_W+1)'(PROGRAM_DEPTH))
        begin
            pc_sum = pc_sum - (PC_W+1)'(PROGRAM_DEPTH);
        end
        pc_out = pc_sum[PC_W-1:0];
    end

endmodule

FILE: hdl/byte_vm_instruction_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_vm_instruction_execute
// two-stage execute core of an eight-bit register machine
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle and returns one result word per
// instruction, valid once the execute stage passes it to the output register.
// The sixteen registers live in a synchronous memory: operands are read on the
// accept edge, the execute cycle computes the result and writes it back on the
// edge that moves it to the output register, and a write that meets a read of
// the same register on one edge is forwarded. Registers read as zero until
// written. The output register takes a new result as the waiting one leaves,
// so the rate is one instruction per cycle whenever m_axis_tready stays high.
// ----------------------------------------------------------------------------
module byte_vm_instruction_execute
#(
    parameter int PROGRAM_DEPTH = bvm_pkg::PROGRAM_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // opcode[7:0], operand[15:8], input_char[23:16]
    input  logic [23:0]                         s_axis_tdata,
    // input_end[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // next_pc[7:0], out_char[15:8]
    output logic [15:0]                         m_axis_tdata,
    // out_valid[0], input_taken[1], zero_out[2], end_seen_out[3], halted_out[4]
    output logic [bvm_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    localparam int PC_W    = $clog2(PROGRAM_DEPTH);
    localparam int RW      = PC_W + 8;
    // smallest multiple of the depth that covers the largest backward jump
    localparam int DEPTH_C = PROGRAM_DEPTH * ((64 + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH);
    localparam int BIAS    = DEPTH_C - 64;

    logic                          accept;
    logic                          advance;

    logic                          ex_valid_reg;
    logic                          ex_valid_next;
    logic [7:0]                    ex_opcode_reg;
    logic [7:0]                    ex_operand_reg;
    logic [7:0]                    ex_char_reg;
    logic                          ex_end_reg;
    logic [PC_W-1:0]               ex_off_reg;

    logic                          zero_reg;
    logic                          end_reg;
    logic                          halt_reg;
    logic [PC_W-1:0]               pc_reg;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [15:0]                   m_data_reg;
    logic [bvm_pkg::OUT_USER_W-1:0] m_user_reg;

    logic [7:0]                    in_operand;
    logic signed [7:0]             op_s;
    logic signed [7:0]             half_s;
    logic [6:0]                    half_biased;
    logic [RW-1:0]                 off_rem;
    logic [PC_W-1:0]               off_mod;

    logic [bvm_pkg::DATA_W-1:0]    rx_val;
    logic [bvm_pkg::DATA_W-1:0]    ry_val;
    bvm_pkg::ex_res_t              res;
    logic [PC_W-1:0]               pc_new;

    assign advance       = ex_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !ex_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_operand    = s_axis_tdata[15:8];

    // jump offset: signed operand halved toward zero, taken modulo depth
    always_comb
    begin
        op_s        = signed'(in_operand);
        half_s      = (op_s + ((op_s < 0) ? 8'sd1 : 8'sd0)) >>> 1;
        half_biased = 7'(half_s + 8'sd64);
        off_rem     = RW'(half_biased) + RW'(BIAS);
        for (int k = 6; k >= 0; k--)
        begin
            if (off_rem >= (RW'(PROGRAM_DEPTH) << k))
            begin
                off_rem = off_rem - (RW'(PROGRAM_DEPTH) << k);
            end
        end
        off_mod = off_rem[PC_W-1:0];
    end

    bvm_regfile u_regfile
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rx_addr (in_operand[bvm_pkg::REG_AW-1:0]),
        .ry_addr (in_operand[7:bvm_pkg::REG_AW]),
        .rx_val  (rx_val),
        .ry_val  (ry_val),
        .we      (advance && res.we),
        .waddr   (res.waddr),
        .wdata   (res.wdata)
    );

    bvm_alu #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_alu
    (
        .opcode     (ex_opcode_reg),
        .operand    (ex_operand_reg),
        .input_char (ex_char_reg),
        .input_end  (ex_end_reg),
        .jump_off   (ex_off_reg),
        .rx_val     (rx_val),
        .ry_val     (ry_val),
        .zero_in    (zero_reg),
        .end_in     (end_reg),
        .halted_in  (halt_reg),
        .pc_in      (pc_reg),
        .res        (res),
        .pc_out     (pc_new)
    );

    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        if (accept)
        begin
            ex_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ex_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            zero_reg     <= 1'b0;
            end_reg      <= 1'b0;
            halt_reg     <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            ex_valid_reg <= ex_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance)
            begin
                zero_reg <= res.zero;
                end_reg  <= res.end_seen;
                halt_reg <= res.halted;
                pc_reg   <= pc_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_opcode_reg  <= s_axis_tdata[7:0];
            ex_operand_reg <= in_operand;
            ex_char_reg    <= s_axis_tdata[23:16];
            ex_end_reg     <= s_axis_tuser[0];
            ex_off_reg     <= off_mod;
        end
        if (advance)
        begin
            m_data_reg <= {res.out_char, 8'(pc_new)};
            m_user_reg <= {res.halted, res.end_seen, res.zero, res.taken, res.out_valid};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: hdl/bvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_checker
// port-level checks of the execute block, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvm_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [15:0]                         m_axis_tdata,
    input  logic [bvm_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    logic out_take;
    logic halt_seen_reg;
    logic halt_seen_next;
    logic end_seen_reg;
    logic end_seen_next;

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        halt_seen_next = halt_seen_reg;
        end_seen_next  = end_seen_reg;
        if (out_take)
        begin
            halt_seen_next = halt_seen_reg || m_axis_tuser[bvm_pkg::UB_HALTED];
            end_seen_next  = end_seen_reg || m_axis_tuser[bvm_pkg::UB_END];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
            end_seen_reg  <= 1'b0;
        end
        else
        begin
            halt_seen_reg <= halt_seen_next;
            end_seen_reg  <= end_seen_next;
        end
    end

    // after a halt, every word stays halted and does no i/o
    `ASSERT_IMPLIES(a_halt_sticky, clk, rst_n, halt_seen_reg && m_axis_tvalid, m_axis_tuser[bvm_pkg::UB_HALTED] && !m_axis_tuser[bvm_pkg::UB_OUT_VALID] && !m_axis_tuser[bvm_pkg::UB_TAKEN])

    // end-of-input flag never drops once reported
    `ASSERT_IMPLIES(a_end_sticky, clk, rst_n, end_seen_reg && m_axis_tvalid, m_axis_tuser[bvm_pkg::UB_END])

    // one instruction cannot both read and emit a character
    `ASSERT_ALWAYS(a_io_excl, clk, rst_n, !(m_axis_tvalid && m_axis_tuser[bvm_pkg::UB_OUT_VALID] && m_axis_tuser[bvm_pkg::UB_TAKEN]))

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind byte_vm_instruction_execute bvm_checker u_bvm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/bvm_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_step_checker
// result checker for the byte machine execute block
// ----------------------------------------------------------------------------
// Watches both stream channels. Every accepted instruction word is run
// through a private copy of the machine state (registers, flags, pc, halt),
// and the result it should give is queued. Every accepted result word is
// compared field by field with the oldest queued result. Mismatches and
// result words with nothing queued are counted and handed to the top.
// ----------------------------------------------------------------------------
module bvm_step_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // opcode[7:0], operand[15:8], input_char[23:16]
    input  logic [23:0]                     s_axis_tdata,
    // input_end[0]
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // next_pc[7:0], out_char[15:8]
    input  logic [15:0]                     m_axis_tdata,
    // out_valid[0], input_taken[1], zero_out[2], end_seen_out[3], halted_out[4]
    input  logic [bvm_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output int                              fail_count,
    output int                              pending
);

    typedef struct packed {
        logic [7:0] next_pc;
        logic       out_valid;
        logic [7:0] out_char;
        logic       taken;
        logic       zero;
        logic       end_seen;
        logic       halted;
    } step_result_t;

    logic [7:0]     regs [bvm_pkg::NUM_REGS];
    logic           zero_flag;
    logic           end_flag;
    logic           halt_flag;
    logic [7:0]     pc;
    step_result_t   pending_results [$];
    step_result_t   got;
    step_result_t   want;
    int             errors = 0;
    int             reports = 0;

    // truncating division of the signed offset byte, kept as an 8-bit step
    function automatic logic [7:0] jump_step(input logic [7:0] offset_byte);
        int offset;
        offset = int'($signed(offset_byte)) / 2;
        return offset[7:0];
    endfunction

    task automatic run_instruction(input logic [7:0] opc, input logic [7:0] opr,
                                   input logic [7:0] ch, input logic at_end);
        step_result_t   r;
        logic [3:0]     rx;
        logic [3:0]     ry;
        logic [7:0]     step;
        logic           sets_zero;
        rx = opr[3:0];
        ry = opr[7:4];
        r = '0;
        step = 8'd1;
        sets_zero = 1'b0;
        if (halt_flag)
        begin
            step = 8'd0;
        end
        else
        begin
            case (opc)
                bvm_pkg::OP_INC:
                begin
                    regs[rx] = regs[rx] + 8'd1;
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_DEC:
                begin
                    regs[rx] = regs[rx] - 8'd1;
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_MOV:  regs[rx] = regs[ry];
                bvm_pkg::OP_MOVC: regs[0] = opr;
                bvm_pkg::OP_LSL:
                begin
                    regs[rx] = {regs[rx][6:0], 1'b0};
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_LSR:
                begin
                    regs[rx] = {1'b0, regs[rx][7:1]};
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_JMP:  step = jump_step(opr);
                bvm_pkg::OP_JZ:   if (zero_flag) step = jump_step(opr);
                bvm_pkg::OP_JNZ:  if (!zero_flag) step = jump_step(opr);
                bvm_pkg::OP_JFE:  if (end_flag) step = jump_step(opr);
                bvm_pkg::OP_RET:
                begin
                    halt_flag = 1'b1;
                    step = 8'd0;
                end
                bvm_pkg::OP_ADD:
                begin
                    regs[rx] = regs[rx] + regs[ry];
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_SUB:
                begin
                    regs[rx] = regs[rx] - regs[ry];
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_XOR:
                begin
                    regs[rx] = regs[rx] ^ regs[ry];
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_OR:
                begin
                    regs[rx] = regs[rx] | regs[ry];
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_IN:
                begin
                    // at end of input the register keeps its value
                    if (at_end)
                    begin
                        end_flag = 1'b1;
                    end
                    else
                    begin
                        regs[rx] = ch;
                        r.taken = 1'b1;
                    end
                    sets_zero = 1'b1;
                end
                bvm_pkg::OP_OUT:
                begin
                    r.out_valid = 1'b1;
                    r.out_char = regs[rx];
                end
                default: ;
            endcase
            if (sets_zero)
                zero_flag = (regs[rx] == 8'h00);
            // pc wraps at 256, the program depth of this build
            pc = pc + step;
        end
        r.next_pc = pc;
        r.zero = zero_flag;
        r.end_seen = end_flag;
        r.halted = halt_flag;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            if (reports < 30)
            begin
                reports++;
                $display("%0t: %s expected %02h got %02h", $time, name, exp_val, act_val);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (regs[i])
                regs[i] = 8'h00;
            zero_flag = 1'b0;
            end_flag = 1'b0;
            halt_flag = 1'b0;
            pc = 8'h00;
            pending_results.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.next_pc = m_axis_tdata[7:0];
                got.out_char = m_axis_tdata[15:8];
                got.out_valid = m_axis_tuser[bvm_pkg::UB_OUT_VALID];
                got.taken = m_axis_tuser[bvm_pkg::UB_TAKEN];
                got.zero = m_axis_tuser[bvm_pkg::UB_ZERO];
                got.end_seen = m_axis_tuser[bvm_pkg::UB_END];
                got.halted = m_axis_tuser[bvm_pkg::UB_HALTED];
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (reports < 30)
                    begin
                        reports++;
                        $display("%0t: result word with no instruction pending, got %h/%h",
                                 $time, m_axis_tdata, m_axis_tuser);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("next_pc", want.next_pc, got.next_pc);
                    compare_field("out_valid", want.out_valid, got.out_valid);
                    compare_field("out_char", want.out_char, got.out_char);
                    compare_field("input_taken", want.taken, got.taken);
                    compare_field("zero_out", want.zero, got.zero);
                    compare_field("end_seen_out", want.end_seen, got.end_seen);
                    compare_field("halted_out", want.halted, got.halted);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                run_instruction(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                s_axis_tdata[23:16], s_axis_tuser[0]);
            pending <= pending_results.size();
        end
        fail_count <= errors;
    end

endmodule

FILE: verif/tb_byte_vm_instruction_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_vm_instruction_execute
// stimulus and verdict for the byte machine execute block
// ----------------------------------------------------------------------------
// Runs a short directed program over every opcode but RET, wrap case and flag case,
// then random instruction words in phases with no idling, a mostly idle
// sender, a mostly stalled receiver and both at once. The run closes with a
// RET and a few words the halted machine must ignore. Checking is done by
// bvm_step_checker beside the block.
// ----------------------------------------------------------------------------
module tb_byte_vm_instruction_execute;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 940;
    localparam int NUM_PHASES   = 4;

    localparam int SEND_IDLE  [NUM_PHASES] = '{0, 86, 0, 29};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 86, 29};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata = '0;
    logic [0:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;
    logic [bvm_pkg::OUT_USER_W-1:0] m_axis_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    int fail_count;
    int pending;

    byte_vm_instruction_execute dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    bvm_step_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one instruction word, held until accepted; tvalid stays up back to back when the sender does not idle
    task automatic send_word(input logic [7:0] opc, input logic [7:0] opr,
                             input logic [7:0] ch, input logic at_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ch, opr, opc};
        s_axis_tuser <= at_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random_word();
        logic [7:0] opc;
        logic [7:0] opr;
        logic [7:0] ch;
        logic       at_end;
        if ($urandom_range(99) < 12)
        begin
            // undefined codes: zero or anything above OUT
            opc = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, 18));
        end
        else
        begin
            // RET is kept for the close of the run
            do
            begin
                opc = 8'($urandom_range(17, 1));
            end
            while (opc == bvm_pkg::OP_RET);
        end
        opr = 8'($urandom);
        // same register on both sides gives zero results for SUB and XOR
        if ($urandom_range(3) == 0)
            opr[7:4] = opr[3:0];
        ch = 8'($urandom);
        at_end = ($urandom_range(99) < 15);
        send_word(opc, opr, ch, at_end);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(bvm_pkg::OP_OUT,  8'h00, 8'h00, 1'b0);   // registers read zero after reset
        send_word(bvm_pkg::OP_INC,  8'h0F, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_DEC,  8'h01, 8'h00, 1'b0);   // wraps to ff
        send_word(bvm_pkg::OP_INC,  8'h01, 8'h00, 1'b0);   // wraps to zero, flag set
        send_word(bvm_pkg::OP_JZ,   8'h7F, 8'h00, 1'b0);   // largest forward jump
        send_word(bvm_pkg::OP_JNZ,  8'h80, 8'h00, 1'b0);   // not taken
        send_word(bvm_pkg::OP_MOVC, 8'hFF, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_MOV,  8'h02, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_LSL,  8'h02, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_LSR,  8'h00, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_ADD,  8'hF2, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_ADD,  8'h22, 8'h00, 1'b0);   // carry out dropped
        send_word(bvm_pkg::OP_SUB,  8'hF3, 8'h00, 1'b0);   // borrow wraps
        send_word(bvm_pkg::OP_XOR,  8'h33, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_OR,   8'h04, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_JNZ,  8'hFF, 8'h00, 1'b0);   // minus one halves to zero
        send_word(bvm_pkg::OP_JMP,  8'h80, 8'h00, 1'b0);   // largest backward jump
        send_word(bvm_pkg::OP_JMP,  8'h01, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_JFE,  8'h40, 8'h00, 1'b0);   // input not ended yet
        send_word(bvm_pkg::OP_IN,   8'h05, 8'hA5, 1'b0);
        send_word(bvm_pkg::OP_IN,   8'h06, 8'h00, 1'b0);
        send_word(bvm_pkg::OP_IN,   8'h05, 8'h3C, 1'b1);   // end of input keeps r5
        send_word(bvm_pkg::OP_JFE,  8'hC0, 8'h00, 1'b0);
        send_word(8'h00,            8'h5A, 8'h00, 1'b0);
        send_word(8'hFF,            8'hA5, 8'hFF, 1'b1);
        send_word(bvm_pkg::OP_OUT,  8'h05, 8'h00, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct = SEND_IDLE[phase];
            recv_stall_pct <= RECV_STALL[phase];
            repeat (RANDOM_WORDS / NUM_PHASES)
                send_random_word();
        end

        // after RET every word is ignored and the pc holds
        send_word(bvm_pkg::OP_RET, 8'($urandom), 8'($urandom), 1'b0);
        repeat (5)
            send_random_word();
        s_axis_tvalid <= 1'b0;
        recv_stall_pct <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bvm_pkg.sv
hdl/bvm_regfile.sv
hdl/bvm_alu.sv
hdl/byte_vm_instruction_execute.sv
hdl/bvm_checker.sv
verif/bvm_step_checker.sv
verif/tb_byte_vm_instruction_execute.sv
